// ===== design/gbfr_pkg.sv =====
`default_nettype none
package gbfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned StatusW = 3;

  localparam logic [ByteW-1:0] BreakByte = 8'h00;
  localparam logic [ByteW-1:0] StartCodeReset = 8'h55;
  localparam logic [ByteW-1:0] SizeMin = 8'd8;
  localparam logic [ByteW-1:0] SizeMax = 8'd252;
  localparam logic [ByteW-1:0] PosBreak = 8'd0;
  localparam logic [ByteW-1:0] PosStart = 8'd1;
  localparam logic [ByteW-1:0] PosSize = 8'd2;
  localparam logic [ByteW-1:0] PosHdrCheck = 8'd9;

  localparam logic [StatusW-1:0] StDiscard = 3'd0;
  localparam logic [StatusW-1:0] StAccept = 3'd1;
  localparam logic [StatusW-1:0] StGood = 3'd2;
  localparam logic [StatusW-1:0] StHdrBad = 3'd3;
  localparam logic [StatusW-1:0] StPayBad = 3'd4;
  localparam logic [StatusW-1:0] StSizeBad = 3'd5;
  localparam logic [StatusW-1:0] StRange = 3'd6;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   byte_position;
    logic [ByteW-1:0]   frame_byte;
  } result_t;

endpackage
`default_nettype wire

// ===== design/gbfr_check.sv =====
`default_nettype none
module gbfr_check
  import gbfr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wen,
  input  wire logic [ByteW-1:0] cfg_wdata,
  input  wire logic             byte_valid,
  input  wire logic [ByteW-1:0] rx_byte,
  output result_t               result
);

  logic [ByteW-1:0] sync_code_r;
  logic [ByteW-1:0] pos_r, pos_nxt;
  logic [ByteW-1:0] size_r, size_nxt;
  logic [ByteW-1:0] hxor_r, hxor_nxt;
  logic [ByteW-1:0] pxor_r, pxor_nxt;
  logic             pok_r, pok_nxt;
  logic [StatusW-1:0] st;
  logic             done;
  logic [ByteW:0]   pay_check_pos;

  // Byte S+2 carries the payload check; one more bit keeps the compare honest.
  assign pay_check_pos = {1'b0, size_r} + (ByteW+1)'(2);

  always_comb begin
    size_nxt = size_r;
    hxor_nxt = hxor_r;
    pxor_nxt = pxor_r;
    pok_nxt  = pok_r;
    done     = 1'b0;
    st       = StAccept;
    priority if (pos_r == PosBreak) begin
      if (rx_byte != BreakByte) begin
        st   = StDiscard;
        done = 1'b1;
      end
    end else if (pos_r == PosStart) begin
      if (rx_byte != sync_code_r) begin
        st   = StDiscard;
        done = 1'b1;
      end
    end else if (pos_r == PosSize) begin
      if (rx_byte < SizeMin || rx_byte > SizeMax) begin
        st   = StRange;
        done = 1'b1;
      end else begin
        size_nxt = rx_byte;
      end
    end else if (pos_r < PosHdrCheck) begin
      hxor_nxt = hxor_r ^ rx_byte;
    end else if (pos_r == PosHdrCheck) begin
      if (rx_byte != hxor_r) begin
        st   = StHdrBad;
        done = 1'b1;
      end
    end else if ({1'b0, pos_r} < pay_check_pos) begin
      pxor_nxt = pxor_r ^ rx_byte;
    end else if ({1'b0, pos_r} == pay_check_pos) begin
      pok_nxt = (rx_byte == pxor_r);
    end else begin
      // Trailer: a bad payload check outranks a size mismatch.
      if (!pok_r) begin
        st = StPayBad;
      end else if (rx_byte != size_r) begin
        st = StSizeBad;
      end else begin
        st = StGood;
      end
      done = 1'b1;
    end

    pos_nxt = pos_r + ByteW'(1);
    if (done) begin
      pos_nxt  = '0;
      size_nxt = '0;
      hxor_nxt = '0;
      pxor_nxt = '0;
      pok_nxt  = 1'b0;
    end
  end

  assign result.frame_byte    = rx_byte;
  assign result.byte_position = pos_r;
  assign result.status        = st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_code_r <= StartCodeReset;
      pos_r       <= '0;
      size_r      <= '0;
      hxor_r      <= '0;
      pxor_r      <= '0;
      pok_r       <= 1'b0;
    end else begin
      if (cfg_wen) begin
        sync_code_r <= cfg_wdata;
      end
      if (byte_valid) begin
        pos_r  <= pos_nxt;
        size_r <= size_nxt;
        hxor_r <= hxor_nxt;
        pxor_r <= pxor_nxt;
        pok_r  <= pok_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/gbfr_out_reg.sv =====
`default_nettype none
module gbfr_out_reg
  import gbfr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic res_valid,
  output logic      res_ready,
  input  result_t   res_in,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   res_out
);

  logic    valid_r;
  result_t data_r;

  // A new word may enter when the register is empty or when the held one leaves in the same cycle.
  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_r <= res_in;
    end
  end

endmodule
`default_nettype wire

// ===== design/gate_bus_frame_receiver.sv =====
// Output: a word accepted at an edge is held in the output register, from which
// out_tvalid and the output fields are driven directly.
// Throughput: one word per cycle while out_tready is high; the single output register
// takes a new word when it is empty or in the same cycle that the held one is taken.
// Reset (rst_n, synchronous, active low) returns the receiver to position 0,
// clears the checksums and the output valid, and sets the start code to 0x55.
`default_nettype none
module gate_bus_frame_receiver
  import gbfr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wen,
  input  wire logic [ByteW-1:0]   cfg_wdata,   // frame start code
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,    // [7:0] rx_byte
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [15:0]             out_tdata,   // [7:0] frame_byte, [15:8] byte_position
  output logic [StatusW-1:0]      out_tuser    // [2:0] status
);

  result_t res;
  result_t res_q;
  logic    accept;

  assign accept = in_tvalid && in_tready;

  gbfr_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .byte_valid (accept),
    .rx_byte    (in_tdata),
    .result     (res)
  );

  gbfr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (in_tvalid),
    .res_ready (in_tready),
    .res_in    (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_out   (res_q)
  );

  assign out_tdata = {res_q.byte_position, res_q.frame_byte};
  assign out_tuser = res_q.status;

endmodule
`default_nettype wire

// ===== tb/gate_bus_frame_receiver_test.sv =====
`timescale 1ns / 100ps
module gate_bus_frame_receiver_test
  import gbfr_pkg::*;
;

  localparam int unsigned LongHold = 300;
  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned WordsPerPhase = 340;
  localparam int unsigned DirectedRows = 21;

  typedef enum {
    FrGood, FrBadBreak, FrBadStart, FrRange, FrHdrBad, FrPayBad, FrTrailBad, FrNoise
  } frame_kind_t;

  typedef struct packed {
    logic [ByteW-1:0]   rx;
    logic               pinned;
    logic [ByteW-1:0]   pos;
    logic [StatusW-1:0] st;
  } directed_row_t;

  typedef struct packed {
    logic    pinned;
    result_t res;
  } typed_entry_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wen = 1'b0;
  logic [ByteW-1:0]   cfg_wdata = '0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [15:0]        out_tdata;
  logic [StatusW-1:0] out_tuser;

  // Frame tracker state, mirrors what the receiver should hold.
  logic [ByteW-1:0] cur_start = StartCodeReset;
  logic [ByteW-1:0] rx_pos = '0;
  logic [ByteW-1:0] frame_size = '0;
  logic [ByteW-1:0] hdr_sum = '0;
  logic [ByteW-1:0] pay_sum = '0;
  logic             pay_ok = 1'b0;

  result_t      pending_results[$];
  typed_entry_t typed_results[$];
  logic [7:0]   frame_q[$];

  int unsigned errors = 0;
  int unsigned words_in = 0;
  int unsigned sent_count = 0;
  int unsigned frames_built = 0;
  int unsigned stuck_cycles = 0;
  int unsigned status_seen[0:7] = '{default: 0};
  logic        send_calm = 1'b0;

  directed_row_t directed_rows [0:DirectedRows-1] = '{
    '{8'h00, 1'b1, 8'd0,  StAccept},
    '{8'h55, 1'b1, 8'd1,  StAccept},
    '{8'h08, 1'b1, 8'd2,  StAccept},
    '{8'h80, 1'b0, 8'd0,  StAccept},
    '{8'h40, 1'b0, 8'd0,  StAccept},
    '{8'h20, 1'b0, 8'd0,  StAccept},
    '{8'h10, 1'b0, 8'd0,  StAccept},
    '{8'h0C, 1'b0, 8'd0,  StAccept},
    '{8'h03, 1'b0, 8'd0,  StAccept},
    '{8'hFF, 1'b0, 8'd0,  StAccept},
    '{8'h00, 1'b0, 8'd0,  StAccept},
    '{8'h08, 1'b1, 8'd11, StGood},
    '{8'hFF, 1'b1, 8'd0,  StDiscard},
    '{8'h00, 1'b1, 8'd0,  StAccept},
    '{8'h54, 1'b1, 8'd1,  StDiscard},
    '{8'h00, 1'b1, 8'd0,  StAccept},
    '{8'h55, 1'b1, 8'd1,  StAccept},
    '{8'h07, 1'b1, 8'd2,  StRange},
    '{8'h00, 1'b1, 8'd0,  StAccept},
    '{8'h55, 1'b1, 8'd1,  StAccept},
    '{8'hFD, 1'b1, 8'd2,  StRange}
  };

  gate_bus_frame_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [7:0] rx_byte
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // [7:0] frame_byte, [15:8] byte_position
    .out_tuser (out_tuser)    // [2:0] status
  );

  always #5 clk = ~clk;

  function automatic void add_frame_byte(input logic [7:0] v);
    frame_q.insert(frame_q.size(), v);
  endfunction

  task automatic clear_frame_state();
    rx_pos = '0;
    frame_size = '0;
    hdr_sum = '0;
    pay_sum = '0;
    pay_ok = 1'b0;
  endtask

  task automatic track_frame_byte(input logic [ByteW-1:0] b, output result_t r);
    logic [StatusW-1:0] st;
    logic               done;
    done = 1'b0;
    if (rx_pos == PosBreak) begin
      st = (b == BreakByte) ? StAccept : StDiscard;
      done = (b != BreakByte);
    end else if (rx_pos == PosStart) begin
      st = (b == cur_start) ? StAccept : StDiscard;
      done = (b != cur_start);
    end else if (rx_pos == PosSize) begin
      if (b < SizeMin || b > SizeMax) begin
        st = StRange;
        done = 1'b1;
      end else begin
        frame_size = b;
        st = StAccept;
      end
    end else if (rx_pos < PosHdrCheck) begin
      hdr_sum = hdr_sum ^ b;
      st = StAccept;
    end else if (rx_pos == PosHdrCheck) begin
      st = (b == hdr_sum) ? StAccept : StHdrBad;
      done = (b != hdr_sum);
    end else if ({1'b0, rx_pos} < {1'b0, frame_size} + 9'd2) begin
      pay_sum = pay_sum ^ b;
      st = StAccept;
    end else if ({1'b0, rx_pos} == {1'b0, frame_size} + 9'd2) begin
      pay_ok = (b == pay_sum);
      st = StAccept;
    end else begin
      // A bad payload checksum takes precedence over a trailer size mismatch.
      if (!pay_ok) st = StPayBad;
      else if (b != frame_size) st = StSizeBad;
      else st = StGood;
      done = 1'b1;
    end
    r.frame_byte = b;
    r.byte_position = rx_pos;
    r.status = st;
    if (done) clear_frame_state();
    else rx_pos = rx_pos + 8'd1;
  endtask

  // Scoreboard, frame tracker and stall watchdog share one process so that the
  // order of push and pop within an edge is fixed.
  always @(posedge clk) begin
    result_t      got;
    result_t      want;
    result_t      model;
    typed_entry_t pin;
    if (!rst_n) begin
      clear_frame_state();
      cur_start = StartCodeReset;
    end else begin
      if (cfg_wen) cur_start = cfg_wdata;
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata};
        status_seen[got.status]++;
        if (pending_results.size() == 0) begin
          $error("unexpected result word: byte %02h position %0d status %0d",
                 got.frame_byte, got.byte_position, got.status);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.frame_byte != want.frame_byte) begin
            $error("frame_byte: expected %02h, actual %02h", want.frame_byte, got.frame_byte);
            errors++;
          end
          if (got.byte_position != want.byte_position) begin
            $error("byte_position: expected %0d, actual %0d",
                   want.byte_position, got.byte_position);
            errors++;
          end
          if (got.status != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        track_frame_byte(in_tdata, model);
        pin = typed_results.pop_front();
        pending_results.insert(pending_results.size(), pin.pinned ? pin.res : model);
        words_in++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("timeout: no word moved for %0d cycles", StuckLimit);
        $display("gate_bus_frame_receiver verification failed");
        $finish;
      end
    end
  end

  // Result side: random stalls, calm stretches, and two long hold-offs that
  // back the receiver up into its input.
  initial begin
    int unsigned stall;
    int unsigned taken;
    logic        calm;
    taken = 0;
    calm = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 16);
      if (taken == 150 || taken == 1000) stall = LongHold;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic pinned, input result_t want);
    int unsigned gap;
    if (sent_count % 50 == 0) send_calm = ($urandom_range(0, 3) == 0);
    gap = send_calm ? 0 : $urandom_range(0, 16);
    typed_results.insert(typed_results.size(), {pinned, want});
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    sent_count++;
  endtask

  task automatic build_frame(input logic [7:0] code);
    frame_kind_t kind;
    int unsigned pick;
    int unsigned size;
    logic [7:0]  hx;
    logic [7:0]  px;
    logic [7:0]  v;
    frame_q.delete();
    pick = $urandom_range(0, 99);
    kind = pick < 45 ? FrGood : pick < 53 ? FrBadBreak : pick < 60 ? FrBadStart :
           pick < 67 ? FrRange : pick < 75 ? FrHdrBad : pick < 83 ? FrPayBad :
           pick < 91 ? FrTrailBad : FrNoise;
    pick = $urandom_range(0, 99);
    size = pick < 90 ? $urandom_range(8, 24) : pick < 97 ? $urandom_range(8, 252) : 252;
    if (kind == FrNoise) begin
      repeat ($urandom_range(1, 6)) add_frame_byte(8'($urandom_range(0, 255)));
      return;
    end
    add_frame_byte(kind == FrBadBreak ? 8'($urandom_range(1, 255)) : BreakByte);
    if (kind == FrBadBreak) return;
    v = (kind == FrBadStart) ? code ^ 8'($urandom_range(1, 255)) : code;
    add_frame_byte(v);
    if (kind == FrBadStart) return;
    if (kind == FrRange) begin
      v = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(253, 255));
      add_frame_byte(v);
      return;
    end
    add_frame_byte(8'(size));
    hx = '0;
    repeat (6) begin
      v = 8'($urandom_range(0, 255));
      hx = hx ^ v;
      add_frame_byte(v);
    end
    add_frame_byte(kind == FrHdrBad ? hx ^ 8'($urandom_range(1, 255)) : hx);
    if (kind == FrHdrBad) return;
    px = '0;
    repeat (size - 8) begin
      v = 8'($urandom_range(0, 255));
      px = px ^ v;
      add_frame_byte(v);
    end
    add_frame_byte(kind == FrPayBad ? px ^ 8'($urandom_range(1, 255)) : px);
    // Payload errors sometimes carry a wrong trailer too, to check precedence.
    if (kind == FrTrailBad || (kind == FrPayBad && $urandom_range(0, 1) == 1))
      add_frame_byte(8'(size) ^ 8'($urandom_range(1, 255)));
    else
      add_frame_byte(8'(size));
  endtask

  task automatic run_frames(input logic [7:0] code, input int unsigned count);
    int unsigned target;
    target = sent_count + count;
    while (sent_count < target) begin
      build_frame(code);
      frames_built++;
      foreach (frame_q[i]) send_byte(frame_q[i], 1'b0, '0);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_start_code(input logic [7:0] code);
    cfg_wen <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    logic [7:0] codes [0:3];
    result_t    row_res;
    codes[0] = 8'h00;
    codes[1] = 8'hFF;
    codes[2] = 8'($urandom_range(1, 254));
    codes[3] = StartCodeReset;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row_res.frame_byte = directed_rows[i].rx;
      row_res.byte_position = directed_rows[i].pos;
      row_res.status = directed_rows[i].st;
      send_byte(directed_rows[i].rx, directed_rows[i].pinned, row_res);
    end
    run_frames(StartCodeReset, WordsPerPhase);

    foreach (codes[i]) begin
      drain();
      write_start_code(codes[i]);
      run_frames(codes[i], WordsPerPhase);
    end
    drain();

    $display("Covered %0d words in %0d generated frames over five start-code phases,",
             words_in, frames_built);
    $display("  with %0d good frames, %0d discards, %0d header, %0d payload,",
             status_seen[StGood], status_seen[StDiscard], status_seen[StHdrBad],
             status_seen[StPayBad]);
    $display("  %0d trailer and %0d size errors.",
             status_seen[StSizeBad], status_seen[StRange]);
    if (errors == 0) begin
      $display("gate_bus_frame_receiver verification clean");
    end else begin
      $display("gate_bus_frame_receiver verification failed");
    end
    $finish;
  end

endmodule
